FILE: rtl/nmea_ll_pkg.sv
// Shared constants, defaults and helper functions for the NMEA lat/lon extractor.
package nmea_ll_pkg;

  // Default parameter values
  localparam int FIELD_CAPACITY_DEF  = 32;
  localparam int FRACTION_DIGITS_DEF = 6;
  localparam int INTEGER_DIGITS_DEF  = 5;

  // Output value width (1e-8 degree units, two's complement)
  localparam int OUT_W = 38;

  // Config register file
  localparam int CFG_W = 5;
  localparam logic REG_LAT_LEN = 1'b0;
  localparam logic REG_LON_LEN = 1'b1;
  localparam logic [CFG_W-1:0] LAT_LEN_RST = 5'd11;
  localparam logic [CFG_W-1:0] LON_LEN_RST = 5'd12;

  // Register stages in the degree conversion pipe
  localparam int CONV_STAGES = 8;

  // ASCII codes
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_W     = 8'h57;

  function automatic longint pow10(input int n);
    longint r;
    r = 1;
    for (int i = 0; i < 18; i++) begin
      if (i < n) r = r * 10;
    end
    return r;
  endfunction

  // Bits needed for a decimal value of n digits
  function automatic int dec_w(input int n);
    return $clog2(pow10(n));
  endfunction

endpackage

FILE: rtl/nmea_ll_conv.sv
// Pipelined conversion of a dddmm.ffff field into signed 1e-8 degree units.
module nmea_ll_conv #(
  parameter int INTEGER_DIGITS  = nmea_ll_pkg::INTEGER_DIGITS_DEF,
  parameter int FRACTION_DIGITS = nmea_ll_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                                                clk_i,
  input  logic [nmea_ll_pkg::CONV_STAGES-1:0]                 adv_i,
  input  logic [nmea_ll_pkg::dec_w(INTEGER_DIGITS)-1:0]       int_i,
  input  logic [nmea_ll_pkg::dec_w(FRACTION_DIGITS)-1:0]      frac_i,
  input  logic                                                neg_i,
  output logic [nmea_ll_pkg::OUT_W-1:0]                       value_o
);
  import nmea_ll_pkg::*;

  localparam int     IntW  = dec_w(INTEGER_DIGITS);
  localparam int     FracW = dec_w(FRACTION_DIGITS);
  // divide by 100: reciprocal multiply, estimate is low by at most one
  localparam int     K1    = IntW + 7;
  localparam longint M100  = (longint'(1) << K1) / 100;
  localparam int     M100W = K1 - 6;
  localparam int     P1W   = IntW + M100W;
  localparam int     DegW  = IntW - 6;
  localparam int     RemW  = 8;
  localparam longint P10F  = pow10(FRACTION_DIGITS);
  localparam longint P10S  = pow10(8 - FRACTION_DIGITS);
  localparam int     MW    = $clog2(100 * P10F);
  localparam int     YW    = $clog2(100 * P10F * P10S + 30);
  localparam int     ZW    = YW - 2;
  // divide by 15: same trick
  localparam longint M15   = (longint'(1) << ZW) / 15;
  localparam int     QW    = ZW - 3;
  localparam int     P2W   = ZW + QW;
  localparam longint E8    = 100000000;
  localparam int     VW    = DegW + 28;

  // stage 0: captured field
  logic [IntW-1:0]  int0_q, int1_q;
  logic [FracW-1:0] frac0_q, frac1_q, frac2_q;
  logic             neg0_q, neg1_q, neg2_q, neg3_q, neg4_q, neg5_q, neg6_q;
  logic [DegW-1:0]  qe1_q, deg2_q, deg3_q, deg4_q, deg5_q, deg6_q;
  logic [RemW-1:0]  rem2_q;
  logic [MW-1:0]    m3_q;
  logic [ZW-1:0]    z4_q, z5_q;
  logic [QW-1:0]    qe5_q, q6_q;
  logic [OUT_W-1:0] out7_q;

  logic [P1W-1:0]   prod1;
  logic [IntW-1:0]  r2;
  logic [DegW-1:0]  deg2_d;
  logic [RemW-1:0]  rem2_d;
  logic [MW-1:0]    m3_d;
  logic [YW-1:0]    y4;
  logic [P2W-1:0]   prod5;
  logic [ZW-1:0]    r6;
  logic [QW-1:0]    q6_d;
  logic [VW-1:0]    mag7;
  logic [63:0]      sval7;

  always_comb begin
    prod1 = P1W'(int0_q) * P1W'(M100);

    r2 = int1_q - IntW'(IntW'(qe1_q) * IntW'(100));
    if (r2 >= IntW'(100)) begin
      deg2_d = qe1_q + DegW'(1);
      rem2_d = RemW'(r2 - IntW'(100));
    end else begin
      deg2_d = qe1_q;
      rem2_d = RemW'(r2);
    end

    m3_d = MW'(rem2_q) * MW'(P10F) + MW'(frac2_q);

    y4 = YW'(m3_q) * YW'(P10S) + YW'(30);

    prod5 = P2W'(z4_q) * P2W'(M15);

    r6 = z5_q - ZW'(ZW'(qe5_q) * ZW'(15));
    q6_d = (r6 >= ZW'(15)) ? qe5_q + QW'(1) : qe5_q;

    mag7  = VW'(deg6_q) * VW'(E8) + VW'(q6_q);
    sval7 = neg6_q ? 64'(0) - 64'(mag7) : 64'(mag7);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      int0_q  <= int_i;
      frac0_q <= frac_i;
      neg0_q  <= neg_i;
    end
    if (adv_i[1]) begin
      int1_q  <= int0_q;
      frac1_q <= frac0_q;
      neg1_q  <= neg0_q;
      qe1_q   <= prod1[P1W-1:K1];
    end
    if (adv_i[2]) begin
      deg2_q  <= deg2_d;
      rem2_q  <= rem2_d;
      frac2_q <= frac1_q;
      neg2_q  <= neg1_q;
    end
    if (adv_i[3]) begin
      m3_q   <= m3_d;
      deg3_q <= deg2_q;
      neg3_q <= neg2_q;
    end
    if (adv_i[4]) begin
      z4_q   <= y4[YW-1:2];
      deg4_q <= deg3_q;
      neg4_q <= neg3_q;
    end
    if (adv_i[5]) begin
      qe5_q  <= prod5[P2W-1:ZW];
      z5_q   <= z4_q;
      deg5_q <= deg4_q;
      neg5_q <= neg4_q;
    end
    if (adv_i[6]) begin
      q6_q   <= q6_d;
      deg6_q <= deg5_q;
      neg6_q <= neg5_q;
    end
    if (adv_i[7]) begin
      out7_q <= sval7[OUT_W-1:0];
    end
  end

  assign value_o = out7_q;

endmodule

FILE: rtl/nmea_lat_lon_extractor_top.sv
// Top level: NMEA byte parser, lat/lon latch and result stream.
// Throughput: one text byte per cycle, sustained while the result side keeps up.
// The result beat shows on m_axis once the end-of-buffer byte has passed through
//   the 8-stage degree conversion pipe.
// The input may stall only while all 8 conversion stages hold results not yet taken.
// Reset (rst_ni low, async): parse state and latches clear, field lengths return
//   to 11 (latitude) and 12 (longitude), pipe empties.
module nmea_lat_lon_extractor_top #(
  parameter int FIELD_CAPACITY  = nmea_ll_pkg::FIELD_CAPACITY_DEF,
  parameter int FRACTION_DIGITS = nmea_ll_pkg::FRACTION_DIGITS_DEF,
  parameter int INTEGER_DIGITS  = nmea_ll_pkg::INTEGER_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [nmea_ll_pkg::CFG_W-1:0] cfg_wdata_i,
  // text byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] text_byte
  input  logic                          s_axis_tlast,   // end_of_buffer
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [79:0]                   m_axis_tdata,   // [37:0] latitude,
                                                        // [75:38] longitude, [79:76] 0
  output logic                          m_axis_tuser    // fix_found
);
  import nmea_ll_pkg::*;

  localparam int LenW = $clog2(FIELD_CAPACITY);
  localparam int CmpW = (LenW > CFG_W) ? LenW : CFG_W;
  localparam int IntW = dec_w(INTEGER_DIGITS);
  localparam int FracW = dec_w(FRACTION_DIGITS);
  localparam int CntW = $clog2(FRACTION_DIGITS + 1);
  localparam int NS = CONV_STAGES;
  localparam logic [IntW-1:0] IMAX = IntW'(pow10(INTEGER_DIGITS) - 1);

  // field parse modes
  localparam logic [1:0] MODE_INT  = 2'd0;
  localparam logic [1:0] MODE_FRAC = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  // config
  logic [CFG_W-1:0] lat_len_q, lon_len_q;

  // current and previous field
  logic [LenW-1:0]  cur_len_q, cur_len_d, prev_len_q, prev_len_d;
  logic             cur_fd_q, cur_fd_d, prev_fd_q, prev_fd_d;
  logic [IntW-1:0]  cur_int_q, cur_int_d, prev_int_q, prev_int_d;
  logic [FracW-1:0] cur_frac_q, cur_frac_d, prev_frac_q, prev_frac_d;
  logic [CntW-1:0]  cur_cnt_q, cur_cnt_d;
  logic [1:0]       mode_q, mode_d;

  // latched raw fields
  logic             lat_latched_q, lat_latched_d, lon_latched_q, lon_latched_d;
  logic [IntW-1:0]  lat_int_q, lat_int_d, lon_int_q, lon_int_d;
  logic [FracW-1:0] lat_frac_q, lat_frac_d, lon_frac_q, lon_frac_d;
  logic             lat_neg_q, lat_neg_d, lon_neg_q, lon_neg_d;

  // conversion pipe control
  logic [NS-1:0]    v_q;
  logic [NS:0]      rdy;
  logic [NS-1:0]    fix_q;

  logic             in_acc, in_last, fix_now;
  logic             is_digit;
  logic [3:0]       dig;
  logic [IntW+3:0]  int_t;
  logic [FracW+3:0] frac_t;
  logic [FracW-1:0] scale;
  logic [2*FracW-1:0] scaled;
  logic [OUT_W-1:0] lat_val, lon_val;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_last = in_acc && s_axis_tlast;

  assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
  assign dig      = s_axis_tdata[3:0];

  // ---------------------------------------------------------------- parser
  always_comb begin
    cur_len_d     = cur_len_q;
    cur_fd_d      = cur_fd_q;
    cur_int_d     = cur_int_q;
    cur_frac_d    = cur_frac_q;
    cur_cnt_d     = cur_cnt_q;
    mode_d        = mode_q;
    prev_len_d    = prev_len_q;
    prev_fd_d     = prev_fd_q;
    prev_int_d    = prev_int_q;
    prev_frac_d   = prev_frac_q;
    lat_latched_d = lat_latched_q;
    lon_latched_d = lon_latched_q;
    lat_int_d     = lat_int_q;
    lat_frac_d    = lat_frac_q;
    lat_neg_d     = lat_neg_q;
    lon_int_d     = lon_int_q;
    lon_frac_d    = lon_frac_q;
    lon_neg_d     = lon_neg_q;

    int_t  = (IntW+4)'(cur_int_q) * (IntW+4)'(10) + (IntW+4)'(dig);
    frac_t = (FracW+4)'(cur_frac_q) * (FracW+4)'(10) + (FracW+4)'(dig);
    // left-align the fraction to FRACTION_DIGITS digits
    scale  = FracW'(pow10(FRACTION_DIGITS - int'(cur_cnt_q)));
    scaled = (2*FracW)'(cur_frac_q) * (2*FracW)'(scale);

    if (in_acc) begin
      if (s_axis_tdata == CH_COMMA || s_axis_tdata == CH_LF) begin
        prev_len_d  = cur_len_q;
        prev_fd_d   = cur_fd_q;
        prev_int_d  = cur_int_q;
        prev_frac_d = scaled[FracW-1:0];
        cur_len_d   = '0;
        cur_fd_d    = 1'b0;
        cur_int_d   = '0;
        cur_frac_d  = '0;
        cur_cnt_d   = '0;
        mode_d      = MODE_INT;
      end else if (cur_len_q < LenW'(FIELD_CAPACITY - 1)) begin
        if (cur_len_q == '0) cur_fd_d = is_digit;
        cur_len_d = cur_len_q + LenW'(1);
        unique case (mode_q)
          MODE_INT: begin
            if (is_digit) begin
              cur_int_d = (int_t > (IntW+4)'(IMAX)) ? IMAX : int_t[IntW-1:0];
            end else if (s_axis_tdata == CH_DOT) begin
              mode_d = MODE_FRAC;
            end else begin
              mode_d = MODE_STOP;
            end
          end
          MODE_FRAC: begin
            if (is_digit) begin
              // digits past the fraction width are dropped
              if (cur_cnt_q < CntW'(FRACTION_DIGITS)) begin
                cur_frac_d = frac_t[FracW-1:0];
                cur_cnt_d  = cur_cnt_q + CntW'(1);
              end
            end else begin
              mode_d = MODE_STOP;
            end
          end
          default: ;
        endcase
      end

      // hemisphere letter checks the field just closed
      if ((s_axis_tdata == CH_N || s_axis_tdata == CH_S) && !lat_latched_q) begin
        if (CmpW'(prev_len_q) == CmpW'(lat_len_q) && prev_fd_q) begin
          lat_int_d     = prev_int_q;
          lat_frac_d    = prev_frac_q;
          lat_neg_d     = (s_axis_tdata == CH_S);
          lat_latched_d = 1'b1;
        end
      end else if ((s_axis_tdata == CH_E || s_axis_tdata == CH_W) && !lon_latched_q) begin
        if (CmpW'(prev_len_q) == CmpW'(lon_len_q) && prev_fd_q) begin
          lon_int_d     = prev_int_q;
          lon_frac_d    = prev_frac_q;
          lon_neg_d     = (s_axis_tdata == CH_W);
          lon_latched_d = 1'b1;
        end
      end
    end
  end

  // fix includes a latch made by the final byte itself
  assign fix_now = lat_latched_d && lon_latched_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_len_q     <= LAT_LEN_RST;
      lon_len_q     <= LON_LEN_RST;
      cur_len_q     <= '0;
      cur_fd_q      <= 1'b0;
      cur_int_q     <= '0;
      cur_frac_q    <= '0;
      cur_cnt_q     <= '0;
      mode_q        <= MODE_INT;
      prev_len_q    <= '0;
      prev_fd_q     <= 1'b0;
      prev_int_q    <= '0;
      prev_frac_q   <= '0;
      lat_latched_q <= 1'b0;
      lon_latched_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_LAT_LEN: lat_len_q <= cfg_wdata_i;
          REG_LON_LEN: lon_len_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_last) begin
        // buffer done: start over
        cur_len_q     <= '0;
        cur_fd_q      <= 1'b0;
        cur_int_q     <= '0;
        cur_frac_q    <= '0;
        cur_cnt_q     <= '0;
        mode_q        <= MODE_INT;
        prev_len_q    <= '0;
        prev_fd_q     <= 1'b0;
        prev_int_q    <= '0;
        prev_frac_q   <= '0;
        lat_latched_q <= 1'b0;
        lon_latched_q <= 1'b0;
      end else begin
        cur_len_q     <= cur_len_d;
        cur_fd_q      <= cur_fd_d;
        cur_int_q     <= cur_int_d;
        cur_frac_q    <= cur_frac_d;
        cur_cnt_q     <= cur_cnt_d;
        mode_q        <= mode_d;
        prev_len_q    <= prev_len_d;
        prev_fd_q     <= prev_fd_d;
        prev_int_q    <= prev_int_d;
        prev_frac_q   <= prev_frac_d;
        lat_latched_q <= lat_latched_d;
        lon_latched_q <= lon_latched_d;
      end
    end
  end

  // raw latched fields: payload only, qualified by the latched flags
  always_ff @(posedge clk_i) begin
    lat_int_q  <= lat_int_d;
    lat_frac_q <= lat_frac_d;
    lat_neg_q  <= lat_neg_d;
    lon_int_q  <= lon_int_d;
    lon_frac_q <= lon_frac_d;
    lon_neg_q  <= lon_neg_d;
  end

  // ---------------------------------------------------------- result pipe
  // A stage loads when it is empty or its successor moves on.
  always_comb begin
    rdy[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_last;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) fix_q[0] <= fix_now;
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) fix_q[k] <= fix_q[k-1];
    end
  end

  // no fix: feed zeros so both values come out zero
  nmea_ll_conv #(
    .INTEGER_DIGITS (INTEGER_DIGITS),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_lat_conv (
    .clk_i  (clk_i),
    .adv_i  (rdy[NS-1:0]),
    .int_i  (fix_now ? lat_int_d : '0),
    .frac_i (fix_now ? lat_frac_d : '0),
    .neg_i  (fix_now && lat_neg_d),
    .value_o(lat_val)
  );

  nmea_ll_conv #(
    .INTEGER_DIGITS (INTEGER_DIGITS),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_lon_conv (
    .clk_i  (clk_i),
    .adv_i  (rdy[NS-1:0]),
    .int_i  (fix_now ? lon_int_d : '0),
    .frac_i (fix_now ? lon_frac_d : '0),
    .neg_i  (fix_now && lon_neg_d),
    .value_o(lon_val)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[NS-1];
  assign m_axis_tuser  = fix_q[NS-1];
  assign m_axis_tdata  = {4'b0, lon_val, lat_val};

  // ------------------------------------------------------------ assertions
  a_nofix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result without fix carries nonzero values");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last |=> !lat_latched_q && !lon_latched_q && cur_len_q == '0 && prev_len_q == '0)
    else $error("parse state not cleared after end of buffer");

  a_latch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lat_latched_q && !in_last |=> lat_latched_q && $stable(lat_int_q) && $stable(lat_frac_q))
    else $error("latitude latch changed inside a buffer");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_len_q <= LenW'(FIELD_CAPACITY - 1) && cur_cnt_q <= CntW'(FRACTION_DIGITS))
    else $error("field length or fraction count out of range");

endmodule

FILE: tb/sv/nmea_fix_checker.sv
`timescale 1ns / 1ps
// Fix checker: watches the text and result streams, predicts each fix result and compares.
module nmea_fix_checker
  import nmea_ll_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [7:0]       s_tdata_i,
  input  logic             s_tlast_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [79:0]      m_tdata_i,
  input  logic             m_tuser_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               fix_count_o
);

  localparam int CAP        = FIELD_CAPACITY_DEF;
  localparam int FRAC_DIGS  = FRACTION_DIGITS_DEF;
  localparam int INT_DIGS   = INTEGER_DIGITS_DEF;

  typedef enum logic [1:0] {MODE_INT, MODE_FRAC, MODE_STOP} num_mode_e;

  typedef struct packed {
    logic             fix;
    logic [OUT_W-1:0] lat;
    logic [OUT_W-1:0] lon;
  } fix_result_t;

  fix_result_t fix_q[$];

  // register copies
  logic [CFG_W-1:0] lat_len, lon_len;

  // field being parsed and the one just closed
  logic [4:0]  cur_len, prev_len;
  logic        cur_first, prev_first;
  logic [16:0] cur_int, prev_int;
  logic [19:0] cur_frac, prev_frac;
  logic [2:0]  cur_fcount;
  num_mode_e   cur_mode;

  logic             lat_ok, lon_ok;
  logic [OUT_W-1:0] lat_val, lon_val;

  fix_result_t      want;
  logic [OUT_W-1:0] got_lat, got_lon;

  function automatic longint unsigned ten_to(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  // closed field as ddd|mm.ffffff -> 1e-8 degree, rounded half up
  function automatic logic [OUT_W-1:0] field_degrees(input bit neg);
    longint unsigned deg, minutes, den, frac, v;
    deg     = prev_int / 100;
    minutes = (prev_int % 100) * ten_to(FRAC_DIGS) + prev_frac;
    den     = 60 * ten_to(FRAC_DIGS);
    frac    = (2 * minutes * 64'd100000000 + den) / (2 * den);
    v       = deg * 64'd100000000 + frac;
    if (neg) v = ~v + 1;
    return v[OUT_W-1:0];
  endfunction

  task automatic clear_parse();
    cur_len = '0; cur_first = 1'b0; cur_int = '0; cur_frac = '0;
    cur_fcount = '0; cur_mode = MODE_INT;
    prev_len = '0; prev_first = 1'b0; prev_int = '0; prev_frac = '0;
    lat_ok = 1'b0; lon_ok = 1'b0; lat_val = '0; lon_val = '0;
  endtask

  task automatic take_byte(input logic [7:0] c, input logic lst);
    bit          is_digit;
    int unsigned t;
    fix_result_t r;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c == CH_COMMA || c == CH_LF) begin
      prev_len   = cur_len;
      prev_first = cur_first;
      prev_int   = cur_int;
      prev_frac  = 20'(cur_frac * ten_to(FRAC_DIGS - cur_fcount));
      cur_len = '0; cur_first = 1'b0; cur_int = '0; cur_frac = '0;
      cur_fcount = '0; cur_mode = MODE_INT;
    end else if (cur_len < CAP - 1) begin
      if (cur_len == 0) cur_first = is_digit;
      cur_len = cur_len + 1;
      case (cur_mode)
        MODE_INT: begin
          if (is_digit) begin
            t = cur_int * 10 + (c - CH_ZERO);
            cur_int = (t > ten_to(INT_DIGS) - 1) ? 17'(ten_to(INT_DIGS) - 1) : 17'(t);
          end else if (c == CH_DOT) begin
            cur_mode = MODE_FRAC;
          end else begin
            cur_mode = MODE_STOP;
          end
        end
        MODE_FRAC: begin
          if (is_digit) begin
            if (cur_fcount < FRAC_DIGS) begin
              cur_frac   = cur_frac * 10 + (c - CH_ZERO);
              cur_fcount = cur_fcount + 1;
            end
          end else begin
            cur_mode = MODE_STOP;
          end
        end
        default: ;
      endcase
    end

    if ((c == CH_N || c == CH_S) && !lat_ok) begin
      if (prev_len == lat_len && prev_first) begin
        lat_val = field_degrees(c == CH_S);
        lat_ok  = 1'b1;
      end
    end else if ((c == CH_E || c == CH_W) && !lon_ok) begin
      if (prev_len == lon_len && prev_first) begin
        lon_val = field_degrees(c == CH_W);
        lon_ok  = 1'b1;
      end
    end

    if (lst) begin
      r.fix = lat_ok && lon_ok;
      r.lat = r.fix ? lat_val : '0;
      r.lon = r.fix ? lon_val : '0;
      fix_q.push_back(r);
      clear_parse();
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    fix_count_o  = 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      lat_len = LAT_LEN_RST;
      lon_len = LON_LEN_RST;
      clear_parse();
      fix_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got_lat = m_tdata_i[OUT_W-1:0];
        got_lon = m_tdata_i[2*OUT_W-1:OUT_W];
        if (fix_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: fix %0b data %h",
                   $time, m_tuser_i, m_tdata_i);
          fail_count_o++;
        end else begin
          want = fix_q.pop_front();
          if (m_tuser_i !== want.fix) begin
            $display("%0t: fix_found expected %0b got %0b", $time, want.fix, m_tuser_i);
            fail_count_o++;
          end
          if (got_lat !== want.lat) begin
            $display("%0t: latitude expected %0d got %0d", $time,
                     $signed(want.lat), $signed(got_lat));
            fail_count_o++;
          end
          if (got_lon !== want.lon) begin
            $display("%0t: longitude expected %0d got %0d", $time,
                     $signed(want.lon), $signed(got_lon));
            fail_count_o++;
          end
          if (m_tuser_i === 1'b1) fix_count_o++;
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_LAT_LEN) lat_len = cfg_wdata_i;
        else lon_len = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) take_byte(s_tdata_i, s_tlast_i);
    end
    pending_o = fix_q.size();
  end

endmodule

FILE: tb/sv/nmea_lat_lon_extractor_top_test.sv
`timescale 1ns / 1ps
// Testbench top: NMEA text stimulus, flow control, length settings and the verdict.
module nmea_lat_lon_extractor_top_test;
  import nmea_ll_pkg::*;

  // Hard stop well past the slowest legal run.
  localparam int unsigned TIMEOUT_NS = 2_000_000;
  // Settle time after the last expected fix: conversion pipe plus margin.
  localparam int DRAIN_CYCLES = CONV_STAGES + 4;
  // Per-phase floor on text bytes and buffers before moving on.
  localparam int PHASE_BYTES   = 100;
  localparam int PHASE_BUFFERS = 6;
  localparam int NUM_PHASES    = 8;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_index_i = REG_LAT_LEN;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;   // [7:0] text_byte
  logic             s_axis_tlast = 1'b0; // end_of_buffer
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [79:0]      m_axis_tdata;        // [37:0] latitude, [75:38] longitude
  logic             m_axis_tuser;        // fix_found

  int fail_count, pending, fix_count;

  // Flow-control knobs, percent of cycles idle on each side.
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  // Text of the buffer being built; last byte goes out with tlast.
  logic [7:0] text_q[$];
  int byte_count = 0;
  int buf_count  = 0;

  // Length settings per phase; extremes 0 and 31 included.
  int lat_tab[NUM_PHASES] = '{11, 0, 31, 4, 31, 1, 9, 11};
  int lon_tab[NUM_PHASES] = '{12, 31, 0, 5, 31, 1, 10, 12};

  nmea_lat_lon_extractor_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  nmea_fix_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .fix_count_o (fix_count)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: one ready decision per falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d fix results still outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Mostly comma, sometimes newline - both close a field.
  function automatic logic [7:0] rand_sep();
    return ($urandom_range(9) == 0) ? CH_LF : CH_COMMA;
  endfunction

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Numeric field of exactly len chars: up to 8 integer digits (past 5 saturates),
  // then a dot and the rest as fraction (past 6 is truncated). Now and then one
  // char is replaced by a random byte, which stops parsing or spoils the lead digit.
  task automatic put_field(input int len);
    int id;
    if (len == 0) return;
    id = $urandom_range(1, (len < 8) ? len : 8);
    for (int i = 0; i < len; i++) begin
      if (i == id) text_q.push_back(CH_DOT);
      else text_q.push_back(rand_digit());
    end
    if ($urandom_range(9) == 0)
      text_q[text_q.size() - 1 - $urandom_range(len - 1)] = 8'($urandom_range(255));
  endtask

  // One coordinate: field, separator, hemisphere letter, separator.
  // Field length is usually the configured one; sometimes anything up to 40
  // so that overlong fields get clipped at the field capacity.
  task automatic put_coord(input bit is_lat, input int want_len);
    int len;
    logic [7:0] letter;
    len = ($urandom_range(4) == 0) ? $urandom_range(0, 40) : want_len;
    put_field(len);
    text_q.push_back(rand_sep());
    if ($urandom_range(9) == 0) letter = 8'($urandom_range(255));
    else if (is_lat) letter = $urandom_range(1) ? CH_S : CH_N;
    else letter = $urandom_range(1) ? CH_W : CH_E;
    text_q.push_back(letter);
    text_q.push_back(rand_sep());
  endtask

  // Sentence-like buffer with random content. A second coordinate pair now
  // and then checks that only the first match latches.
  task automatic build_sentence(input int lat_len, input int lon_len);
    bit lon_first;
    int pairs;
    case ($urandom_range(3))
      0: put_str("$GPGGA,092750.000,");
      1: put_str("$GNRMC,A,");
      2: put_str("V,");
      default: ;
    endcase
    lon_first = ($urandom_range(4) == 0);
    pairs = ($urandom_range(4) == 0) ? 2 : 1;
    for (int p = 0; p < pairs; p++) begin
      if (lon_first) begin
        put_coord(1'b0, lon_len);
        put_coord(1'b1, lat_len);
      end else begin
        put_coord(1'b1, lat_len);
        put_coord(1'b0, lon_len);
      end
    end
    // drop the trailing separator half the time so the buffer can end on E/W
    if ($urandom_range(1)) void'(text_q.pop_back());
    else put_str("1,08,0.9*47\n");
  endtask

  task automatic build_random_buffer(input int lat_len, input int lon_len);
    int kind, n;
    kind = $urandom_range(99);
    if (kind < 70) begin
      build_sentence(lat_len, lon_len);
    end else if (kind < 88) begin
      // broken sentence: random bytes dropped in, or cut short
      build_sentence(lat_len, lon_len);
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 3))
          text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      end else begin
        n = $urandom_range(1, text_q.size());
        while (text_q.size() > n) void'(text_q.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 16)) text_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] c, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    byte_count += text_q.size();
    buf_count++;
    text_q.delete();
  endtask

  // Stop sending, wait for every expected fix, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Both length registers, back to back, with one enable pulse.
  task automatic set_lengths(input logic [CFG_W-1:0] lat_len, input logic [CFG_W-1:0] lon_len);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_LAT_LEN;
    cfg_wdata_i <= lat_len;
    @(negedge clk_i);
    cfg_index_i <= REG_LON_LEN;
    cfg_wdata_i <= lon_len;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int ph_bytes, ph_bufs;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset lengths (11/12), no idling:
    // south/west fix, empty previous field, zero byte and 0xFF as lone buffers.
    put_str("4807.038000,S,01131.000000,W");
    send_buffer();
    put_str(",N,E");
    send_buffer();
    text_q.push_back(8'h00);
    send_buffer();
    text_q.push_back(8'hFF);
    send_buffer();
    drain();

    // Random phases: each new length pair, flow pattern cycles none/src/sink/both.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_lengths(CFG_W'(lat_tab[ph]), CFG_W'(lon_tab[ph]));
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 78; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 78; end
        default: begin src_idle_pct = 12; snk_stall_pct = 12; end
      endcase
      ph_bytes = byte_count;
      ph_bufs  = buf_count;
      while (byte_count - ph_bytes < PHASE_BYTES || buf_count - ph_bufs < PHASE_BUFFERS) begin
        build_random_buffer(lat_tab[ph], lon_tab[ph]);
        send_buffer();
      end
      drain();
    end

    $display("covered %0d text bytes in %0d buffers, %0d of them ending with a fix,",
             byte_count, buf_count, fix_count);
    $display("over %0d field length settings and four flow-control patterns",
             NUM_PHASES + 1);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/nmea_ll_pkg.sv
rtl/nmea_ll_conv.sv
rtl/nmea_lat_lon_extractor_top.sv
tb/sv/nmea_fix_checker.sv
tb/sv/nmea_lat_lon_extractor_top_test.sv
